// ----- rtl/fsq_pkg.sv -----
package fsq_pkg;

   localparam int PORT_WIDTH          = 32;
   localparam int DEF_WORD_WIDTH      = 32;
   localparam int DEF_EXP_WIDTH       = 8;
   // root digits resolved per pipeline stage
   localparam int STEPS_PER_STAGE     = 4;

endpackage

// ----- rtl/float_square_root_unit.sv -----
// float_square_root_unit: square root of one raw float word per beat.
// Format: WORD_WIDTH bits (sign, EXP_WIDTH-bit biased exponent, fraction)
// in the low bits of req_operand_bits; rsp_root_bits holds the root in the
// same format with the bits above WORD_WIDTH at zero.
// A beat is taken at each rising edge where start is high and busy is low.
// busy is always low: the pipeline takes one operand every cycle.
// Each result shows on rsp_root_bits for one cycle with rsp_valid high,
// in the order the operands came in.
// The pipeline has NUM_STAGES root stages, where NUM_STAGES is ceil((F + 2) / 4)
// and F is the fraction width. The root is resolved four digits per stage of
// a restoring digit-by-digit pipeline.
// Zero/subnormal inputs give a signed zero, +inf gives +inf, NaN and negatives
// give a NaN with only the lowest fraction bit set; normals are rounded to nearest even.
// Synchronous reset clears every stage valid bit; beats in flight are lost.
// The receiver cannot stall, so results are never held back.
module float_square_root_unit #(
   parameter int WORD_WIDTH = fsq_pkg::DEF_WORD_WIDTH,
   parameter int EXP_WIDTH  = fsq_pkg::DEF_EXP_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [fsq_pkg::PORT_WIDTH-1:0] req_operand_bits,
   output logic                           rsp_valid,
   output logic [fsq_pkg::PORT_WIDTH-1:0] rsp_root_bits
);
   import fsq_pkg::*;

   localparam int W      = WORD_WIDTH;
   localparam int E      = EXP_WIDTH;
   localparam int F      = W - E - 1;
   localparam int N      = F + 2;
   localparam int REM_W  = N + 2;
   localparam int RAD_W  = 2 * N;
   localparam int NS     = (N + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam logic [E-1:0] BIAS     = E'((1 << (E - 1)) - 1);
   localparam logic [E-1:0] EXP_ONES = {E{1'b1}};

   // decode
   logic          in_sign;
   logic [E-1:0]  in_expo;
   logic [F-1:0]  in_frac;
   logic          in_spec;
   logic [W-1:0]  in_spec_val;
   logic [F+1:0]  in_sig;
   logic [E-1:0]  in_expo_adj;
   logic [E:0]    in_exp_sum;
   logic          accept;

   assign busy    = 1'b0;
   assign accept  = start & ~busy;
   assign in_sign = req_operand_bits[W-1];
   assign in_expo = req_operand_bits[W-2:F];
   assign in_frac = req_operand_bits[F-1:0];

   always_comb begin
      in_spec     = 1'b1;
      in_spec_val = {1'b0, EXP_ONES, {(F-1){1'b0}}, 1'b1};
      if (in_expo == '0) begin
         in_spec_val = {in_sign, {(W-1){1'b0}}};
      end else if (in_expo == EXP_ONES) begin
         if (in_frac == '0 && !in_sign) begin
            in_spec_val = {1'b0, EXP_ONES, {F{1'b0}}};
         end
      end else if (!in_sign) begin
         in_spec = 1'b0;
      end
   end

   // unbiased exponent is odd when the biased one is even (bias is odd)
   assign in_sig      = in_expo[0] ? {1'b0, 1'b1, in_frac} : {1'b1, in_frac, 1'b0};
   assign in_expo_adj = in_expo - {{(E-1){1'b0}}, ~in_expo[0]};
   assign in_exp_sum  = {1'b0, in_expo_adj} + {1'b0, BIAS};

   // pipeline stage registers
   logic             valid_ff [0:NS];
   logic             spec_ff  [0:NS];
   logic [W-1:0]     sval_ff  [0:NS];
   logic [E-1:0]     exp_ff   [0:NS];
   logic [RAD_W-1:0] rad_ff   [0:NS];
   logic [REM_W-1:0] rem_ff   [0:NS];
   logic [N-1:0]     root_ff  [0:NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= accept;
      end
      spec_ff[0] <= in_spec;
      sval_ff[0] <= in_spec_val;
      exp_ff[0]  <= in_exp_sum[E:1];
      rad_ff[0]  <= {in_sig, {N{1'b0}}};
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [RAD_W-1:0] rad_in;
      logic [REM_W-1:0] rem_in;
      logic [N-1:0]     root_in;

      always_comb begin
         logic [REM_W-1:0] trial;
         rad_in  = rad_ff[k];
         rem_in  = rem_ff[k];
         root_in = root_ff[k];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            if (k * STEPS_PER_STAGE + j < N) begin
               rem_in = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
               rad_in = {rad_in[RAD_W-3:0], 2'b00};
               trial  = {root_in, 2'b01};
               if (rem_in >= trial) begin
                  rem_in  = rem_in - trial;
                  root_in = {root_in[N-2:0], 1'b1};
               end else begin
                  root_in = {root_in[N-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         spec_ff[k+1] <= spec_ff[k];
         sval_ff[k+1] <= sval_ff[k];
         exp_ff[k+1]  <= exp_ff[k];
         rad_ff[k+1]  <= rad_in;
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
      end
   end

   // round to nearest even, renormalize on carry
   logic [F+1:0] rnd_sum;
   logic         rnd_inc;
   logic [F-1:0] out_frac;
   logic [E-1:0] out_exp;
   logic [W-1:0] out_word_in;
   logic         rsp_valid_ff;
   logic [W-1:0] rsp_word_ff;

   assign rnd_inc  = root_ff[NS][0] & ((rem_ff[NS] != '0) | root_ff[NS][1]);
   assign rnd_sum  = {1'b0, root_ff[NS][N-1:1]} + {{(F+1){1'b0}}, rnd_inc};
   assign out_frac = rnd_sum[F+1] ? rnd_sum[F:1] : rnd_sum[F-1:0];
   assign out_exp  = exp_ff[NS] + {{(E-1){1'b0}}, rnd_sum[F+1]};
   assign out_word_in = spec_ff[NS] ? sval_ff[NS] : {1'b0, out_exp, out_frac};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[NS];
      end
      rsp_word_ff <= out_word_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root_bits = PORT_WIDTH'(rsp_word_ff);

   // a negative result is only ever a negative zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_ff[W-1] |-> rsp_word_ff[W-2:0] == '0)
      else $error("negative nonzero root");

   // a normal root never lands on the all-ones exponent
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[NS] && !spec_ff[NS] |=> rsp_word_ff[W-2:F] != EXP_ONES)
      else $error("normal root overflowed exponent");

   // valid bits advance one stage per cycle
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |=> valid_ff[1])
      else $error("beat dropped in first root stage");

   // leading root digit is set for every normal operand
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[NS] && !spec_ff[NS] |-> root_ff[NS][N-1] || root_ff[NS][N-2])
      else $error("root not normalized");

endmodule

// ----- tb/sv/float_square_root_checker.sv -----
`timescale 1ns / 100ps

module float_square_root_checker #(
   parameter int WORD_WIDTH = fsq_pkg::DEF_WORD_WIDTH,
   parameter int EXP_WIDTH  = fsq_pkg::DEF_EXP_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [fsq_pkg::PORT_WIDTH-1:0] req_operand_bits,
   input  logic                           rsp_valid,
   input  logic [fsq_pkg::PORT_WIDTH-1:0] rsp_root_bits,
   output int                             fail_count,
   output int                             roots_pending
);

   localparam int FRAC_W = WORD_WIDTH - EXP_WIDTH - 1;

   logic [fsq_pkg::PORT_WIDTH-1:0] expected_roots[$];

   function automatic logic [fsq_pkg::PORT_WIDTH-1:0] predict_root(
      input logic [fsq_pkg::PORT_WIDTH-1:0] word);
      logic [63:0] frac_mask, exp_ones, word_mask, raw, sgn, expo, frac, qnan;
      logic [63:0] sig, rad, rem, root, trial, rounded;
      longint bias, unb, res_exp;
      frac_mask = (64'd1 << FRAC_W) - 1;
      exp_ones  = (64'd1 << EXP_WIDTH) - 1;
      word_mask = (64'd1 << WORD_WIDTH) - 1;
      bias      = (64'sd1 <<< (EXP_WIDTH - 1)) - 1;
      raw  = {32'd0, word} & word_mask;
      sgn  = (raw >> (WORD_WIDTH - 1)) & 64'd1;
      expo = (raw >> FRAC_W) & exp_ones;
      frac = raw & frac_mask;
      qnan = (exp_ones << FRAC_W) | 64'd1;
      if (expo == 0) return 32'(sgn << (WORD_WIDTH - 1));
      if (expo == exp_ones) begin
         if (frac == 0 && sgn == 0) return 32'(exp_ones << FRAC_W);
         return 32'(qnan);
      end
      if (sgn != 0) return 32'(qnan);
      unb = longint'(expo) - bias;
      sig = (64'd1 << FRAC_W) | frac;
      if (unb[0]) begin
         sig = sig << 1;
         unb = unb - 1;
      end
      rad  = sig << (FRAC_W + 2);
      rem  = 0;
      root = 0;
      for (int i = 0; i < 32; i++) begin
         rem   = (rem << 2) | (rad >> 62);
         rad   = rad << 2;
         root  = root << 1;
         trial = (root << 1) | 64'd1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = root | 64'd1;
         end
      end
      rounded = root >> 1;
      if (root[0] && (rem != 0 || rounded[0])) rounded = rounded + 1;
      res_exp = unb / 2 + bias;
      if (rounded >= (64'd1 << (FRAC_W + 1))) begin
         rounded = rounded >> 1;
         res_exp = res_exp + 1;
      end
      return 32'((((64'(res_exp) & exp_ones) << FRAC_W) | (rounded & frac_mask))
                 & word_mask);
   endfunction

   initial begin
      fail_count    = 0;
      roots_pending = 0;
   end

   always @(posedge clock) begin
      logic [fsq_pkg::PORT_WIDTH-1:0] want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_roots.size() == 0) begin
               $display("%0t: unexpected root beat, expected none, actual %h",
                        $time, rsp_root_bits);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_roots.pop_front();
               if (rsp_root_bits !== want) begin
                  $display("%0t: root mismatch, expected %h, actual %h",
                           $time, want, rsp_root_bits);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) expected_roots.push_back(predict_root(req_operand_bits));
      end
      roots_pending <= expected_roots.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic [31:0] req_operand_bits = '0;
   logic        busy, rsp_valid;
   logic [31:0] rsp_root_bits;
   int          fail_count, roots_pending;
   int          idle_cycles = 0;
   logic [31:0] operand_list[$];

   float_square_root_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operand_bits(req_operand_bits),
      .rsp_valid(rsp_valid), .rsp_root_bits(rsp_root_bits)
   );

   float_square_root_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operand_bits(req_operand_bits), .rsp_valid(rsp_valid),
      .rsp_root_bits(rsp_root_bits), .fail_count(fail_count),
      .roots_pending(roots_pending)
   );

   always #6 clock = ~clock;

   // watchdog: cycles with no beat on either side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [31:0] random_operand();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(9))
         0: w[30:23] = 8'h00;
         1: w[30:23] = 8'hff;
         2: w[22:0] = {23{1'b1}};
         3: w[22:0] = 23'd0;
         4, 5: w[31] = 1'b0;
         default: ;
      endcase
      if ($urandom_range(9) < 6) w[31] = 1'b0;
      return w;
   endfunction

   task automatic send_operand(input logic [31:0] w);
      int gap;
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(2);
      if ($urandom_range(3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_operand_bits <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      operand_list = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807f_ffff,
                       32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'h7f80_0001,
                       32'hffff_ffff, 32'hbf80_0000, 32'h8080_0000, 32'h3f80_0000,
                       32'h4000_0000, 32'h4080_0000, 32'h0080_0000, 32'h0080_0001,
                       32'h7f7f_ffff, 32'h3fff_ffff, 32'h3f7f_ffff, 32'h4040_0000,
                       32'h5555_5555, 32'h2aaa_aaaa, 32'h7f00_0000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (operand_list[i]) send_operand(operand_list[i]);
      start <= 1'b0;
      // drain fully once
      do @(posedge clock); while (roots_pending != 0);
      for (int i = 0; i < 1630; i++) send_operand(random_operand());
      start <= 1'b0;
      do @(posedge clock); while (roots_pending != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && roots_pending == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
